### rtl/core/tuft_pkg.sv
// Shared types, constants and helpers of the timed union-find tree.
`default_nettype none
package tuft_pkg;

  localparam int MAX_LEAVES = 1024;
  localparam int LEVELS     = 11;
  localparam int TIME_BITS  = 32;
  localparam int SLOTS      = 2 * MAX_LEAVES;
  localparam int NODE_W     = $clog2(SLOTS);
  localparam int LVL_W      = $clog2(LEVELS + 1);
  localparam int JT_DEPTH   = LEVELS * SLOTS;
  localparam int JT_AW      = LVL_W + NODE_W;

  localparam logic [1:0] MODE_INIT  = 2'd0;
  localparam logic [1:0] MODE_UNION = 2'd1;
  localparam logic [1:0] MODE_BUILD = 2'd2;
  localparam logic [1:0] MODE_QUERY = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_PHASE = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  localparam logic [1:0] PH_INIT  = 2'd0;
  localparam logic [1:0] PH_UNION = 2'd1;
  localparam logic [1:0] PH_QUERY = 2'd2;

  typedef enum logic [4:0] {
    OP_IDLE, OP_LOAD, OP_ERR_PHASE, OP_ERR_RANGE,
    OP_INIT_START, OP_INIT_WR,
    OP_FIND_START, OP_FIND_RD, OP_FIND_CHK, OP_COMP_RD, OP_COMP_WR,
    OP_ROOT_A, OP_ROOT_B, OP_NOMERGE, OP_LT_RD_A, OP_LT_RD_B, OP_MERGE_WR1, OP_MERGE_WR2,
    OP_BUILD_START, OP_B0_RD, OP_B0_WR, OP_BJ_RD1, OP_BJ_RD2, OP_BJ_WR, OP_BUILD_DONE,
    OP_Q_START, OP_Q_RD1, OP_Q_RD2, OP_Q_CHK, OP_Q_SZRD, OP_Q_SZ,
    OP_EMIT
  } dp_op_t;

  typedef enum logic [4:0] {
    S_IDLE, S_DECODE, S_INIT,
    S_FIND_RD, S_FIND_CHK, S_COMP_CHK, S_COMP_RD, S_COMP_WR, S_ROOT,
    S_MERGE_DEC, S_LT_A, S_LT_B, S_MW1, S_MW2,
    S_B0_RD, S_B0_WR, S_BJ_RD1, S_BJ_RD2, S_BJ_WR, S_BDONE,
    S_Q_RD1, S_Q_RD2, S_Q_CHK, S_Q_SZRD, S_Q_SZ,
    S_DONE
  } ctl_state_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       phase_bad;
    logic       range_bad;
    logic       fp_self;
    logic       cur_is_root;
    logic       sel_b;
    logic       can_merge;
    logic       init_last;
    logic       idx_last;
    logic       lvl_one;
    logic       lvl_last;
    logic       lvl_zero;
  } dp_stat_t;

  // Bit length of a node number, capped at the number of lifting levels.
  function automatic logic [LVL_W-1:0] level_count(input logic [NODE_W-1:0] v);
    logic [LVL_W-1:0] l;
    l = '0;
    for (int i = 0; i < NODE_W; i++) begin
      if (v[i]) l = LVL_W'(i + 1);
    end
    if (l > LVL_W'(LEVELS)) l = LVL_W'(LEVELS);
    return l;
  endfunction

endpackage
`default_nettype wire

### rtl/core/timed_union_find_tree.sv
// Top level of the timed union-find tree: controller plus datapath.
// One item is worked on at a time; in_tready is high only while idle.
// Init writes entries 1 to 2n-1 of the node stores. Union finds both roots, compressing
// each find path, and merges distinct roots under a new node. Build fills the ancestor
// table level by level. Query climbs it from the top level and reads the leaf count.
// rst_n is synchronous, active low; it clears phase, counters and handshake state only.
`default_nettype none
module timed_union_find_tree
  import tuft_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [10:0] cfg_wr_data,    // node_count
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [55:0] in_tdata,       // node_a[10:0], node_b[21:11], query_time[53:22]
  input  wire logic [1:0]  in_tuser,       // mode[1:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata       // merged[0], found_node[11:1],
                                           // component_size[22:12], status[24:23]
);

  dp_cmd_t           cmd;
  dp_stat_t          stat;
  logic              o_merged;
  logic [NODE_W-1:0] o_found, o_size;
  logic [1:0]        o_status;

  tuft_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  tuft_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_mode     (in_tuser),
    .in_a        (in_tdata[10:0]),
    .in_b        (in_tdata[21:11]),
    .in_qt       (in_tdata[53:22]),
    .cmd         (cmd),
    .stat        (stat),
    .out_merged  (o_merged),
    .out_found   (o_found),
    .out_size    (o_size),
    .out_status  (o_status)
  );

  assign out_tdata = {7'd0, o_status, o_size, o_found, o_merged};

endmodule
`default_nettype wire

### rtl/core/tuft_ctrl.sv
// Controller state machine that sequences the union-find datapath.
`default_nettype none
module tuft_ctrl
  import tuft_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_tvalid,
  output logic          in_tready,
  output logic          out_tvalid,
  input  wire logic     out_tready,
  input  wire dp_stat_t stat,
  output dp_cmd_t       cmd
);

  ctl_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign out_free   = !out_valid_r || out_tready;
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:     if (in_tvalid) state_nxt = S_DECODE;
      S_DECODE: begin
        if (stat.phase_bad || stat.range_bad) begin
          state_nxt = S_DONE;
        end else begin
          case (stat.mode)
            MODE_INIT:  state_nxt = S_INIT;
            MODE_UNION: state_nxt = S_FIND_RD;
            MODE_BUILD: state_nxt = S_B0_RD;
            default:    state_nxt = S_Q_RD1;
          endcase
        end
      end
      S_INIT:     if (stat.init_last) state_nxt = S_DONE;
      S_FIND_RD:  state_nxt = S_FIND_CHK;
      S_FIND_CHK: state_nxt = stat.fp_self ? S_COMP_CHK : S_FIND_RD;
      S_COMP_CHK: state_nxt = stat.cur_is_root ? S_ROOT : S_COMP_RD;
      S_COMP_RD:  state_nxt = S_COMP_WR;
      S_COMP_WR:  state_nxt = S_COMP_CHK;
      S_ROOT:     state_nxt = stat.sel_b ? S_MERGE_DEC : S_FIND_RD;
      S_MERGE_DEC: state_nxt = stat.can_merge ? S_LT_A : S_DONE;
      S_LT_A:     state_nxt = S_LT_B;
      S_LT_B:     state_nxt = S_MW1;
      S_MW1:      state_nxt = S_MW2;
      S_MW2:      state_nxt = S_DONE;
      S_B0_RD:    state_nxt = S_B0_WR;
      S_B0_WR: begin
        if (!stat.idx_last)    state_nxt = S_B0_RD;
        else if (stat.lvl_one) state_nxt = S_BDONE;
        else                   state_nxt = S_BJ_RD1;
      end
      S_BJ_RD1:   state_nxt = S_BJ_RD2;
      S_BJ_RD2:   state_nxt = S_BJ_WR;
      S_BJ_WR:    state_nxt = (stat.idx_last && stat.lvl_last) ? S_BDONE : S_BJ_RD1;
      S_BDONE:    state_nxt = S_DONE;
      S_Q_RD1:    state_nxt = S_Q_RD2;
      S_Q_RD2:    state_nxt = S_Q_CHK;
      S_Q_CHK:    state_nxt = stat.lvl_zero ? S_Q_SZRD : S_Q_RD1;
      S_Q_SZRD:   state_nxt = S_Q_SZ;
      S_Q_SZ:     state_nxt = S_DONE;
      S_DONE:     if (out_free) state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd.op        = OP_IDLE;
    out_valid_nxt = out_valid_r && !out_tready;
    case (state_r)
      S_IDLE:   if (in_tvalid) cmd.op = OP_LOAD;
      S_DECODE: begin
        if (stat.phase_bad)      cmd.op = OP_ERR_PHASE;
        else if (stat.range_bad) cmd.op = OP_ERR_RANGE;
        else begin
          case (stat.mode)
            MODE_INIT:  cmd.op = OP_INIT_START;
            MODE_UNION: cmd.op = OP_FIND_START;
            MODE_BUILD: cmd.op = OP_BUILD_START;
            default:    cmd.op = OP_Q_START;
          endcase
        end
      end
      S_INIT:      cmd.op = OP_INIT_WR;
      S_FIND_RD:   cmd.op = OP_FIND_RD;
      S_FIND_CHK:  cmd.op = OP_FIND_CHK;
      S_COMP_CHK:  cmd.op = OP_IDLE;
      S_COMP_RD:   cmd.op = OP_COMP_RD;
      S_COMP_WR:   cmd.op = OP_COMP_WR;
      S_ROOT:      cmd.op = stat.sel_b ? OP_ROOT_B : OP_ROOT_A;
      S_MERGE_DEC: cmd.op = stat.can_merge ? OP_IDLE : OP_NOMERGE;
      S_LT_A:      cmd.op = OP_LT_RD_A;
      S_LT_B:      cmd.op = OP_LT_RD_B;
      S_MW1:       cmd.op = OP_MERGE_WR1;
      S_MW2:       cmd.op = OP_MERGE_WR2;
      S_B0_RD:     cmd.op = OP_B0_RD;
      S_B0_WR:     cmd.op = OP_B0_WR;
      S_BJ_RD1:    cmd.op = OP_BJ_RD1;
      S_BJ_RD2:    cmd.op = OP_BJ_RD2;
      S_BJ_WR:     cmd.op = OP_BJ_WR;
      S_BDONE:     cmd.op = OP_BUILD_DONE;
      S_Q_RD1:     cmd.op = OP_Q_RD1;
      S_Q_RD2:     cmd.op = OP_Q_RD2;
      S_Q_CHK:     cmd.op = OP_Q_CHK;
      S_Q_SZRD:    cmd.op = OP_Q_SZRD;
      S_Q_SZ:      cmd.op = OP_Q_SZ;
      S_DONE: begin
        if (out_free) begin
          cmd.op        = OP_EMIT;
          out_valid_nxt = 1'b1;
        end
      end
      default:     cmd.op = OP_IDLE;
    endcase
  end

`ifndef SYNTHESIS
  a_accept_decode: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == S_DECODE))
    else $error("accepted item did not reach decode");
  a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_EMIT) |=> out_valid_r)
    else $error("emitted result not presented");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && !out_free) |=> (state_r == S_DONE))
    else $error("left done state while output was blocked");
`endif

endmodule
`default_nettype wire

### rtl/core/tuft_dp.sv
// Datapath of the timed union-find tree: stores, sweep counters and result registers.
`default_nettype none
module tuft_dp
  import tuft_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_wr_en,
  input  wire logic [NODE_W-1:0]    cfg_wr_data,
  input  wire logic [1:0]           in_mode,
  input  wire logic [NODE_W-1:0]    in_a,
  input  wire logic [NODE_W-1:0]    in_b,
  input  wire logic [TIME_BITS-1:0] in_qt,
  input  wire dp_cmd_t              cmd,
  output dp_stat_t                  stat,
  output logic                      out_merged,
  output logic [NODE_W-1:0]         out_found,
  output logic [NODE_W-1:0]         out_size,
  output logic [1:0]                out_status
);

  logic [NODE_W-1:0]    fp_mem [0:SLOTS-1];
  logic [NODE_W-1:0]    tp_mem [0:SLOTS-1];
  logic [NODE_W-1:0]    lt_mem [0:SLOTS-1];
  logic [TIME_BITS-1:0] st_mem [0:SLOTS-1];
  logic [NODE_W-1:0]    jt_mem [0:JT_DEPTH-1];

  logic [NODE_W-1:0]    fp_q, tp_q, lt_q, jt_q;
  logic [TIME_BITS-1:0] st_q;

  logic [NODE_W-1:0]    node_count_r, next_node_r;
  logic [TIME_BITS-1:0] clock_r;
  logic [1:0]           phase_r;
  logic [LVL_W-1:0]     lvl_total_r;

  logic [1:0]           mode_r;
  logic [NODE_W-1:0]    a_r, b_r, n2_r, idx_r, cur_r, root_r, ra_r, rb_r, size_a_r, up_r;
  logic [TIME_BITS-1:0] qt_r;
  logic [LVL_W-1:0]     lvl_r;
  logic                 sel_b_r;
  logic                 res_merged_r;
  logic [NODE_W-1:0]    res_found_r, res_size_r;
  logic [1:0]           res_status_r;

  logic [NODE_W-1:0]    n_clamp, start_node, new_node;
  logic [LVL_W-1:0]     lvl_m1;

  always_comb begin
    n_clamp = node_count_r;
    if (node_count_r == '0) n_clamp = NODE_W'(1);
    if (node_count_r > NODE_W'(MAX_LEAVES)) n_clamp = NODE_W'(MAX_LEAVES);
  end

  assign start_node = sel_b_r ? b_r : a_r;
  assign new_node   = next_node_r + NODE_W'(1);
  assign lvl_m1     = lvl_r - LVL_W'(1);

  always_comb begin
    stat.mode      = mode_r;
    case (mode_r)
      MODE_INIT:  stat.phase_bad = (phase_r != PH_INIT);
      MODE_QUERY: stat.phase_bad = (phase_r != PH_QUERY);
      default:    stat.phase_bad = (phase_r != PH_UNION);
    endcase
    case (mode_r)
      MODE_UNION: stat.range_bad = (a_r == '0) || (b_r == '0) ||
                                   (a_r > next_node_r) || (b_r > next_node_r);
      MODE_QUERY: stat.range_bad = (a_r == '0) || (a_r > next_node_r);
      default:    stat.range_bad = 1'b0;
    endcase
    stat.fp_self     = (fp_q == cur_r);
    stat.cur_is_root = (cur_r == root_r);
    stat.sel_b       = sel_b_r;
    stat.can_merge   = (ra_r != rb_r) && (next_node_r != NODE_W'(SLOTS - 1));
    stat.init_last   = (idx_r == n2_r);
    stat.idx_last    = (idx_r == next_node_r);
    stat.lvl_one     = (lvl_total_r == LVL_W'(1));
    stat.lvl_last    = (lvl_r == lvl_total_r - LVL_W'(1));
    stat.lvl_zero    = (lvl_r == '0);
  end

  // Architectural state that reset clears.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= NODE_W'(1);
      next_node_r  <= '0;
      clock_r      <= '0;
      phase_r      <= PH_INIT;
      lvl_total_r  <= '0;
    end else begin
      if (cfg_wr_en) node_count_r <= cfg_wr_data;
      case (cmd.op)
        OP_INIT_WR: begin
          if (idx_r == n2_r) begin
            next_node_r <= n_clamp;
            clock_r     <= '0;
            phase_r     <= PH_UNION;
          end
        end
        OP_ROOT_B:      if (clock_r != '1) clock_r <= clock_r + TIME_BITS'(1);
        OP_MERGE_WR1:   next_node_r <= new_node;
        OP_BUILD_START: lvl_total_r <= level_count(next_node_r);
        OP_BUILD_DONE:  phase_r <= PH_QUERY;
        default: ;
      endcase
    end
  end

  // Working registers of one item.
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        mode_r       <= in_mode;
        a_r          <= in_a;
        b_r          <= in_b;
        qt_r         <= in_qt;
        res_merged_r <= 1'b0;
        res_found_r  <= '0;
        res_size_r   <= '0;
        res_status_r <= ST_OK;
      end
      OP_ERR_PHASE: res_status_r <= ST_PHASE;
      OP_ERR_RANGE: res_status_r <= ST_RANGE;
      OP_INIT_START: begin
        idx_r <= NODE_W'(1);
        n2_r  <= NODE_W'({n_clamp, 1'b0} - (NODE_W + 1)'(1));
      end
      OP_INIT_WR: idx_r <= idx_r + NODE_W'(1);
      OP_FIND_START: begin
        cur_r   <= a_r;
        sel_b_r <= 1'b0;
      end
      OP_FIND_CHK: begin
        if (fp_q == cur_r) begin
          root_r <= cur_r;
          cur_r  <= start_node;
        end else begin
          cur_r <= fp_q;
        end
      end
      OP_COMP_WR: cur_r <= fp_q;
      OP_ROOT_A: begin
        ra_r    <= root_r;
        sel_b_r <= 1'b1;
        cur_r   <= b_r;
      end
      OP_ROOT_B:    rb_r <= root_r;
      OP_NOMERGE:   res_found_r <= ra_r;
      OP_LT_RD_B:   size_a_r <= lt_q;
      OP_MERGE_WR2: begin
        res_merged_r <= 1'b1;
        res_found_r  <= next_node_r;
      end
      OP_BUILD_START: begin
        idx_r <= NODE_W'(1);
        lvl_r <= '0;
      end
      OP_B0_WR, OP_BJ_WR: begin
        if (idx_r == next_node_r) begin
          idx_r <= NODE_W'(1);
          lvl_r <= lvl_r + LVL_W'(1);
        end else begin
          idx_r <= idx_r + NODE_W'(1);
        end
      end
      OP_Q_START: begin
        cur_r <= a_r;
        lvl_r <= lvl_total_r - LVL_W'(1);
      end
      OP_Q_RD2: up_r <= jt_q;
      OP_Q_CHK: begin
        if (st_q <= qt_r) cur_r <= up_r;
        lvl_r <= lvl_m1;
      end
      OP_Q_SZ: begin
        res_found_r <= cur_r;
        res_size_r  <= lt_q;
      end
      OP_EMIT: begin
        out_merged <= res_merged_r;
        out_found  <= res_found_r;
        out_size   <= res_size_r;
        out_status <= res_status_r;
      end
      default: ;
    endcase
  end

  // Union-find parent store.
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_INIT_WR:   fp_mem[idx_r] <= idx_r;
      OP_COMP_WR:   fp_mem[cur_r] <= root_r;
      OP_MERGE_WR1: fp_mem[ra_r]  <= new_node;
      OP_MERGE_WR2: fp_mem[rb_r]  <= next_node_r;
      default: ;
    endcase
    if (cmd.op == OP_FIND_RD || cmd.op == OP_COMP_RD) fp_q <= fp_mem[cur_r];
  end

  // Merge-tree parent store.
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_INIT_WR:   tp_mem[idx_r] <= idx_r;
      OP_MERGE_WR1: tp_mem[ra_r]  <= new_node;
      OP_MERGE_WR2: tp_mem[rb_r]  <= next_node_r;
      default: ;
    endcase
    if (cmd.op == OP_B0_RD) tp_q <= tp_mem[idx_r];
  end

  // Leaf counts.
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_INIT_WR:   lt_mem[idx_r]    <= NODE_W'(1);
      OP_MERGE_WR1: lt_mem[new_node] <= size_a_r + lt_q;
      default: ;
    endcase
    case (cmd.op)
      OP_LT_RD_A: lt_q <= lt_mem[ra_r];
      OP_LT_RD_B: lt_q <= lt_mem[rb_r];
      OP_Q_SZRD:  lt_q <= lt_mem[cur_r];
      default: ;
    endcase
  end

  // Merge stamps.
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_INIT_WR:   st_mem[idx_r]    <= '0;
      OP_MERGE_WR1: st_mem[new_node] <= clock_r;
      default: ;
    endcase
    if (cmd.op == OP_Q_RD2) st_q <= st_mem[jt_q];
  end

  // Ancestor table, addressed as {level, node}.
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_B0_WR: jt_mem[{LVL_W'(0), idx_r}] <= tp_q;
      OP_BJ_WR: jt_mem[{lvl_r, idx_r}]     <= jt_q;
      default: ;
    endcase
    case (cmd.op)
      OP_BJ_RD1: jt_q <= jt_mem[{lvl_m1, idx_r}];
      OP_BJ_RD2: jt_q <= jt_mem[{lvl_m1, jt_q}];
      OP_Q_RD1:  jt_q <= jt_mem[{lvl_r, cur_r}];
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_phase_legal: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_BUILD_DONE) |=> (phase_r == PH_QUERY && lvl_total_r != '0))
    else $error("build finished without levels");
  a_init_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_INIT_WR) |-> (idx_r != '0 && idx_r <= n2_r))
    else $error("init sweep index out of range");
  a_merge_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_MERGE_WR1) |-> (ra_r != rb_r && ra_r <= next_node_r))
    else $error("merge of bad roots");
`endif

endmodule
`default_nettype wire
